// ===== rtl/core/psd_pkg.sv =====
// Shared constants and types for the point-to-segment distance pipeline.
// No dependencies; every module of the block imports this package.
package psd_pkg;

   localparam int DEF_COORD_BITS    = 24;
   localparam int DEF_FRACTION_BITS = 12;
   localparam int DEF_RATIO_BITS    = 16;

   // Result distance width (unsigned Q13.12) and its byte-padded bus width.
   localparam int DIST_BITS     = 25;
   localparam int RSP_DATA_BITS = ((DIST_BITS + 7) / 8) * 8;

   // How the projection ratio is chosen for one transaction.
   typedef enum logic [2:0] {
      SEL_ZERO = 3'b001,
      SEL_ONE  = 3'b010,
      SEL_DIV  = 3'b100
   } ratio_sel_type;

endpackage

// ===== rtl/core/point_segment_distance.sv =====
// Top level of the point-to-segment distance pipeline.
// Depends on psd_pkg, psd_front, psd_div, psd_proj and psd_sqrt.
//
// Usage: each transaction on the req_ channel carries one query point and one
// segment (start, end) as signed fixed-point coordinates. Each query yields
// exactly one transaction on the rsp_ channel, in order: the floor of the
// Euclidean distance to the nearest point of the segment, plus a flag in
// rsp_tuser that is set when the segment has zero length and the distance to
// its start point was reported instead.
// Throughput is one transaction per cycle while the receiver takes results.
// Each result is registered through the front end, the restoring divider, the
// projection and the digit-by-digit square root; the divider and the square
// root set most of the pipeline depth.
// The whole pipeline advances together: when rsp_tvalid is high and the
// receiver holds rsp_tready low, every stage holds and req_tready drops, so
// nothing is lost or repeated. While the output is empty or being taken,
// req_tready stays high even with results in flight.
// Reset is synchronous and clears all valid bits; the data registers need no
// reset, so the block is ready in the cycle after reset falls.
module point_segment_distance #(
   parameter int COORD_BITS    = psd_pkg::DEF_COORD_BITS,
   parameter int FRACTION_BITS = psd_pkg::DEF_FRACTION_BITS,
   parameter int RATIO_BITS    = psd_pkg::DEF_RATIO_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0 up: query_x, query_y, seg_start_x, seg_start_y,
   // seg_end_x, seg_end_y, then zero padding to a whole byte.
   input  logic [((6*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0 up: distance, then zero padding.
   output logic [psd_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // Fields from bit 0 up: degenerate.
   output logic                                  rsp_tuser
);
   import psd_pkg::*;

   localparam int DW   = COORD_BITS + 1;
   localparam int LW   = 2 * DW + 1;
   localparam int SQRT_BITS = ((COORD_BITS + 3) > DIST_BITS) ? (COORD_BITS + 3) : DIST_BITS;

   logic                       en;
   logic signed [COORD_BITS-1:0] qx, qy, sx, sy, ex, ey;

   logic                 f_valid, f_degen;
   logic signed [DW-1:0] f_dx, f_dy, f_rx, f_ry;
   logic [LW-1:0]        f_len2;
   logic signed [LW-1:0] f_dot;

   logic                 d_valid, d_degen;
   logic signed [DW-1:0] d_dx, d_dy, d_rx, d_ry;
   logic [RATIO_BITS:0]  d_ratio;

   logic                   p_valid, p_degen;
   logic [2*SQRT_BITS-1:0] p_sum;

   logic [SQRT_BITS-1:0] root;

   // Single pipeline enable: advance unless a finished result is stuck.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign qx = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign qy = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign sx = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign sy = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign ex = req_tdata[4*COORD_BITS +: COORD_BITS];
   assign ey = req_tdata[5*COORD_BITS +: COORD_BITS];

   psd_front #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid),
      .query_x     (qx),
      .query_y     (qy),
      .seg_start_x (sx),
      .seg_start_y (sy),
      .seg_end_x   (ex),
      .seg_end_y   (ey),
      .out_valid   (f_valid),
      .out_dx      (f_dx),
      .out_dy      (f_dy),
      .out_rx      (f_rx),
      .out_ry      (f_ry),
      .out_len2    (f_len2),
      .out_dot     (f_dot),
      .out_degen   (f_degen)
   );

   psd_div #(
      .COORD_BITS (COORD_BITS),
      .RATIO_BITS (RATIO_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_dx     (f_dx),
      .in_dy     (f_dy),
      .in_rx     (f_rx),
      .in_ry     (f_ry),
      .in_len2   (f_len2),
      .in_dot    (f_dot),
      .in_degen  (f_degen),
      .out_valid (d_valid),
      .out_dx    (d_dx),
      .out_dy    (d_dy),
      .out_rx    (d_rx),
      .out_ry    (d_ry),
      .out_ratio (d_ratio),
      .out_degen (d_degen)
   );

   psd_proj #(
      .COORD_BITS (COORD_BITS),
      .RATIO_BITS (RATIO_BITS),
      .SQRT_BITS  (SQRT_BITS)
   ) u_proj (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_dx     (d_dx),
      .in_dy     (d_dy),
      .in_rx     (d_rx),
      .in_ry     (d_ry),
      .in_ratio  (d_ratio),
      .in_degen  (d_degen),
      .out_valid (p_valid),
      .out_sum   (p_sum),
      .out_degen (p_degen)
   );

   psd_sqrt #(
      .SQRT_BITS (SQRT_BITS)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .in_value  (p_sum),
      .in_degen  (p_degen),
      .out_valid (rsp_tvalid),
      .out_root  (root),
      .out_degen (rsp_tuser)
   );

   // The distance is the low DIST_BITS of the root, zero-padded to the bus.
   assign rsp_tdata = {{(RSP_DATA_BITS-DIST_BITS){1'b0}}, root[DIST_BITS-1:0]};

endmodule

// ===== rtl/core/psd_front.sv =====
// Front end: segment and offset vectors, their products, squared length and dot.
// Depends on psd_pkg.
module psd_front #(
   parameter int COORD_BITS    = psd_pkg::DEF_COORD_BITS,
   parameter int FRACTION_BITS = psd_pkg::DEF_FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [COORD_BITS-1:0]      query_x,
   input  logic signed [COORD_BITS-1:0]      query_y,
   input  logic signed [COORD_BITS-1:0]      seg_start_x,
   input  logic signed [COORD_BITS-1:0]      seg_start_y,
   input  logic signed [COORD_BITS-1:0]      seg_end_x,
   input  logic signed [COORD_BITS-1:0]      seg_end_y,
   output logic                              out_valid,
   output logic signed [COORD_BITS:0]        out_dx,
   output logic signed [COORD_BITS:0]        out_dy,
   output logic signed [COORD_BITS:0]        out_rx,
   output logic signed [COORD_BITS:0]        out_ry,
   output logic [2*COORD_BITS+2:0]           out_len2,
   output logic signed [2*COORD_BITS+2:0]    out_dot,
   output logic                              out_degen
);
   import psd_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int LW = PW + 1;
   localparam logic [63:0] DEGEN_LIMIT = (64'd1 << (2 * FRACTION_BITS)) / 64'd1000000000000;

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff, rx1_ff, ry1_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff, rx2_ff, ry2_ff;
   logic signed [DW-1:0] dx3_ff, dy3_ff, rx3_ff, ry3_ff;
   logic signed [PW-1:0] dxx_ff, dyy_ff, rxdx_ff, rydy_ff;
   logic [LW-1:0]        len2_ff, len2_in;
   logic signed [LW-1:0] dot_ff, dot_in;
   logic                 degen_ff;

   always_comb begin
      len2_in = {1'b0, dxx_ff} + {1'b0, dyy_ff};
      dot_in  = $signed({rxdx_ff[PW-1], rxdx_ff}) + $signed({rydy_ff[PW-1], rydy_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff <= $signed({seg_end_x[COORD_BITS-1], seg_end_x})
                 - $signed({seg_start_x[COORD_BITS-1], seg_start_x});
         dy1_ff <= $signed({seg_end_y[COORD_BITS-1], seg_end_y})
                 - $signed({seg_start_y[COORD_BITS-1], seg_start_y});
         rx1_ff <= $signed({query_x[COORD_BITS-1], query_x})
                 - $signed({seg_start_x[COORD_BITS-1], seg_start_x});
         ry1_ff <= $signed({query_y[COORD_BITS-1], query_y})
                 - $signed({seg_start_y[COORD_BITS-1], seg_start_y});
         dxx_ff  <= dx1_ff * dx1_ff;
         dyy_ff  <= dy1_ff * dy1_ff;
         rxdx_ff <= rx1_ff * dx1_ff;
         rydy_ff <= ry1_ff * dy1_ff;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         rx2_ff  <= rx1_ff;
         ry2_ff  <= ry1_ff;
         len2_ff  <= len2_in;
         dot_ff   <= dot_in;
         degen_ff <= (len2_in <= DEGEN_LIMIT[LW-1:0]);
         dx3_ff   <= dx2_ff;
         dy3_ff   <= dy2_ff;
         rx3_ff   <= rx2_ff;
         ry3_ff   <= ry2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_dx    = dx3_ff;
   assign out_dy    = dy3_ff;
   assign out_rx    = rx3_ff;
   assign out_ry    = ry3_ff;
   assign out_len2  = len2_ff;
   assign out_dot   = dot_ff;
   assign out_degen = degen_ff;

endmodule

// ===== rtl/core/psd_div.sv =====
// Projection ratio: clamping plus a restoring divider with one quotient bit per stage.
// Depends on psd_pkg.
module psd_div #(
   parameter int COORD_BITS = psd_pkg::DEF_COORD_BITS,
   parameter int RATIO_BITS = psd_pkg::DEF_RATIO_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [COORD_BITS:0]        in_dx,
   input  logic signed [COORD_BITS:0]        in_dy,
   input  logic signed [COORD_BITS:0]        in_rx,
   input  logic signed [COORD_BITS:0]        in_ry,
   input  logic [2*COORD_BITS+2:0]           in_len2,
   input  logic signed [2*COORD_BITS+2:0]    in_dot,
   input  logic                              in_degen,
   output logic                              out_valid,
   output logic signed [COORD_BITS:0]        out_dx,
   output logic signed [COORD_BITS:0]        out_dy,
   output logic signed [COORD_BITS:0]        out_rx,
   output logic signed [COORD_BITS:0]        out_ry,
   output logic [RATIO_BITS:0]               out_ratio,
   output logic                              out_degen
);
   import psd_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int LW = 2 * DW + 1;
   localparam int RW = LW + 1;
   localparam int NS = RATIO_BITS + 1;

   logic                  v_ff     [NS];
   ratio_sel_type         sel_ff   [NS];
   logic [LW-1:0]         len2_ff  [NS];
   logic [RW-1:0]         rem_ff   [NS];
   logic [RW-1:0]         rem_in   [NS];
   logic [RATIO_BITS-1:0] q_ff     [NS];
   logic [RATIO_BITS-1:0] q_in     [NS];
   logic signed [DW-1:0]  dx_ff    [NS];
   logic signed [DW-1:0]  dy_ff    [NS];
   logic signed [DW-1:0]  rx_ff    [NS];
   logic signed [DW-1:0]  ry_ff    [NS];
   logic                  degen_ff [NS];
   ratio_sel_type         sel_in;
   logic [RW-1:0]         shifted;

   // Degenerate segments and non-positive dots use ratio zero; dot at or past
   // the squared length clamps to one; everything else is divided.
   always_comb begin
      if (in_degen || in_dot[LW-1] || (in_dot == '0)) begin
         sel_in = SEL_ZERO;
      end else if ($unsigned(in_dot) >= in_len2) begin
         sel_in = SEL_ONE;
      end else begin
         sel_in = SEL_DIV;
      end
      rem_in[0] = (sel_in == SEL_DIV) ? {1'b0, $unsigned(in_dot)} : '0;
      q_in[0]   = '0;
      shifted   = '0;
      for (int k = 1; k < NS; k++) begin
         shifted = {rem_ff[k-1][RW-2:0], 1'b0};
         if (shifted >= {1'b0, len2_ff[k-1]}) begin
            rem_in[k] = shifted - {1'b0, len2_ff[k-1]};
            q_in[k]   = {q_ff[k-1][RATIO_BITS-2:0], 1'b1};
         end else begin
            rem_in[k] = shifted;
            q_in[k]   = {q_ff[k-1][RATIO_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sel_ff[0]   <= sel_in;
         len2_ff[0]  <= in_len2;
         rem_ff[0]   <= rem_in[0];
         q_ff[0]     <= q_in[0];
         dx_ff[0]    <= in_dx;
         dy_ff[0]    <= in_dy;
         rx_ff[0]    <= in_rx;
         ry_ff[0]    <= in_ry;
         degen_ff[0] <= in_degen;
         for (int k = 1; k < NS; k++) begin
            sel_ff[k]   <= sel_ff[k-1];
            len2_ff[k]  <= len2_ff[k-1];
            rem_ff[k]   <= rem_in[k];
            q_ff[k]     <= q_in[k];
            dx_ff[k]    <= dx_ff[k-1];
            dy_ff[k]    <= dy_ff[k-1];
            rx_ff[k]    <= rx_ff[k-1];
            ry_ff[k]    <= ry_ff[k-1];
            degen_ff[k] <= degen_ff[k-1];
         end
      end
   end

   always_comb begin
      case (sel_ff[NS-1])
         SEL_ZERO: out_ratio = '0;
         SEL_ONE:  out_ratio = {1'b1, {RATIO_BITS{1'b0}}};
         SEL_DIV:  out_ratio = {1'b0, q_ff[NS-1]};
         default:  out_ratio = '0;
      endcase
   end

   assign out_valid = v_ff[NS-1];
   assign out_dx    = dx_ff[NS-1];
   assign out_dy    = dy_ff[NS-1];
   assign out_rx    = rx_ff[NS-1];
   assign out_ry    = ry_ff[NS-1];
   assign out_degen = degen_ff[NS-1];

`ifndef ASSERT_OFF
   // A stalled pipeline must not move the valid bits of its first and last stages.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(v_ff[0]) && $stable(v_ff[NS-1])))
      else $error("divider valid bits moved during a stall");

   // An enabled cycle loads the entry stage from the input.
   a_entry_load: assert property (@(posedge clock) disable iff (reset)
      en |=> (v_ff[0] == $past(in_valid)))
      else $error("divider entry stage lost an input");

   // Degenerate segments always leave with ratio zero.
   a_degen_ratio: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_degen) |-> (out_ratio == '0))
      else $error("degenerate transaction with nonzero ratio");
`endif

endmodule

// ===== rtl/core/psd_proj.sv =====
// Closest point and squared offset: ratio scaling, subtraction, squares and sum.
// Depends on psd_pkg.
module psd_proj #(
   parameter int COORD_BITS = psd_pkg::DEF_COORD_BITS,
   parameter int RATIO_BITS = psd_pkg::DEF_RATIO_BITS,
   parameter int SQRT_BITS  = psd_pkg::DIST_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_BITS:0]    in_dx,
   input  logic signed [COORD_BITS:0]    in_dy,
   input  logic signed [COORD_BITS:0]    in_rx,
   input  logic signed [COORD_BITS:0]    in_ry,
   input  logic [RATIO_BITS:0]           in_ratio,
   input  logic                          in_degen,
   output logic                          out_valid,
   output logic [2*SQRT_BITS-1:0]        out_sum,
   output logic                          out_degen
);
   import psd_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int OW = COORD_BITS + 3;
   localparam int MW = RATIO_BITS + 1 + DW;
   localparam int SW = 2 * OW;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic                 g1_ff, g2_ff, g3_ff, g4_ff;
   logic [MW-1:0]        mx_ff, my_ff;
   logic                 nx_ff, ny_ff;
   logic signed [DW-1:0] rx1_ff, ry1_ff;
   logic signed [OW-1:0] ox_ff, oy_ff, ox_in, oy_in, sx, sy;
   logic [SW-1:0]        oxx_ff, oyy_ff;
   logic [SW-1:0]        sum_ff;
   logic [DW-1:0]        adx, ady;

   always_comb begin
      adx = in_dx[DW-1] ? $unsigned(-in_dx) : $unsigned(in_dx);
      ady = in_dy[DW-1] ? $unsigned(-in_dy) : $unsigned(in_dy);
      // Scaled component is truncated toward zero, then given the sign of d.
      sx  = $signed({2'b00, mx_ff[RATIO_BITS +: DW]});
      sy  = $signed({2'b00, my_ff[RATIO_BITS +: DW]});
      if (nx_ff) sx = -sx;
      if (ny_ff) sy = -sy;
      ox_in = $signed({{2{rx1_ff[DW-1]}}, rx1_ff}) - sx;
      oy_in = $signed({{2{ry1_ff[DW-1]}}, ry1_ff}) - sy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff  <= MW'(in_ratio) * MW'(adx);
         my_ff  <= MW'(in_ratio) * MW'(ady);
         nx_ff  <= in_dx[DW-1];
         ny_ff  <= in_dy[DW-1];
         rx1_ff <= in_rx;
         ry1_ff <= in_ry;
         g1_ff  <= in_degen;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         g2_ff  <= g1_ff;
         oxx_ff <= $unsigned(SW'(ox_ff) * SW'(ox_ff));
         oyy_ff <= $unsigned(SW'(oy_ff) * SW'(oy_ff));
         g3_ff  <= g2_ff;
         sum_ff <= oxx_ff + oyy_ff;
         g4_ff  <= g3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_sum   = (2*SQRT_BITS)'(sum_ff);
   assign out_degen = g4_ff;

endmodule

// ===== rtl/core/psd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage (floor of the root).
// Depends on psd_pkg.
module psd_sqrt #(
   parameter int SQRT_BITS = psd_pkg::DIST_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [2*SQRT_BITS-1:0]     in_value,
   input  logic                       in_degen,
   output logic                       out_valid,
   output logic [SQRT_BITS-1:0]       out_root,
   output logic                       out_degen
);
   import psd_pkg::*;

   localparam int NW  = 2 * SQRT_BITS;
   localparam int RMW = SQRT_BITS + 2;

   logic                 v_ff     [SQRT_BITS];
   logic                 g_ff     [SQRT_BITS];
   logic [NW-1:0]        n_ff     [SQRT_BITS];
   logic [NW-1:0]        n_in     [SQRT_BITS];
   logic [RMW-1:0]       rem_ff   [SQRT_BITS];
   logic [RMW-1:0]       rem_in   [SQRT_BITS];
   logic [SQRT_BITS-1:0] root_ff  [SQRT_BITS];
   logic [SQRT_BITS-1:0] root_in  [SQRT_BITS];
   logic [RMW-1:0]       pre, trial;

   always_comb begin
      pre   = '0;
      trial = '0;
      for (int j = 0; j < SQRT_BITS; j++) begin
         if (j == 0) begin
            pre   = {{(RMW-2){1'b0}}, in_value[NW-1 -: 2]};
            trial = {{(RMW-2){1'b0}}, 2'b01};
            n_in[j] = {in_value[NW-3:0], 2'b00};
         end else begin
            pre   = {rem_ff[j-1][RMW-3:0], n_ff[j-1][NW-1 -: 2]};
            trial = {root_ff[j-1], 2'b01};
            n_in[j] = {n_ff[j-1][NW-3:0], 2'b00};
         end
         if (pre >= trial) begin
            rem_in[j]  = pre - trial;
            root_in[j] = (j == 0) ? SQRT_BITS'(1) : {root_ff[j-1][SQRT_BITS-2:0], 1'b1};
         end else begin
            rem_in[j]  = pre;
            root_in[j] = (j == 0) ? '0 : {root_ff[j-1][SQRT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SQRT_BITS; j++) begin
            v_ff[j] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int j = 1; j < SQRT_BITS; j++) begin
            v_ff[j] <= v_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff[0] <= in_degen;
         for (int j = 1; j < SQRT_BITS; j++) begin
            g_ff[j] <= g_ff[j-1];
         end
         for (int j = 0; j < SQRT_BITS; j++) begin
            n_ff[j]    <= n_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign out_valid = v_ff[SQRT_BITS-1];
   assign out_root  = root_ff[SQRT_BITS-1];
   assign out_degen = g_ff[SQRT_BITS-1];

endmodule

// ===== verif/point_segment_distance_tb.sv =====
// Self-checking testbench for the point-to-segment distance pipeline.
// Depends on psd_pkg and point_segment_distance; predicts each result in 64-bit arithmetic.
module point_segment_distance_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = psd_pkg::DEF_COORD_BITS;
   localparam int RB = psd_pkg::DEF_RATIO_BITS;
   localparam int REQ_W = ((6*CB+7)/8)*8;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // Fields from bit 0 up: query_x, query_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y.
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // Fields from bit 0 up: distance, then zero padding.
   logic [psd_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   // Fields from bit 0 up: degenerate.
   logic rsp_tuser;

   typedef struct packed {
      logic [24:0] distance;
      logic        degenerate;
   } dist_result_type;

   dist_result_type pending_distances[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  allow_gaps = 1'b1;

   point_segment_distance dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Scales a signed delta by ratio / 2^RB, rounding toward zero.
   function automatic logic signed [63:0] scale_delta(logic [63:0] ratio,
                                                       logic signed [63:0] d);
      if (d < 0) return -((ratio * (-d)) >> RB);
      return (ratio * d) >> RB;
   endfunction

   function automatic dist_result_type predict_distance(logic [REQ_W-1:0] item);
      logic signed [63:0] qx, qy, sx, sy, ex, ey, dx, dy, rx, ry, ox, oy, dot;
      logic [63:0] len2, ratio, rem;
      dist_result_type r;
      qx = $signed(item[0*CB +: CB]);
      qy = $signed(item[1*CB +: CB]);
      sx = $signed(item[2*CB +: CB]);
      sy = $signed(item[3*CB +: CB]);
      ex = $signed(item[4*CB +: CB]);
      ey = $signed(item[5*CB +: CB]);
      dx = ex - sx;
      dy = ey - sy;
      len2 = dx * dx + dy * dy;
      rx = qx - sx;
      ry = qy - sy;
      r.degenerate = (len2 == 0);
      if (r.degenerate) begin
         ox = rx;
         oy = ry;
      end else begin
         dot = rx * dx + ry * dy;
         if (dot <= 0) ratio = 0;
         else if (dot >= $signed(len2)) ratio = 64'd1 << RB;
         else begin
            rem = dot;
            ratio = 0;
            for (int i = 0; i < RB; i++) begin
               rem = rem << 1;
               ratio = ratio << 1;
               if (rem >= len2) begin
                  rem = rem - len2;
                  ratio = ratio | 64'd1;
               end
            end
         end
         ox = rx - scale_delta(ratio, dx);
         oy = ry - scale_delta(ratio, dy);
      end
      r.distance = root_floor(ox * ox + oy * oy);
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   // Sends one query transaction, with a random gap ahead of it when gaps are on.
   task automatic send_query(logic [CB-1:0] qx, qy, sx, sy, ex, ey);
      logic [REQ_W-1:0] item;
      int gap;
      item = '0;
      item[6*CB-1:0] = {ey, ex, sy, sx, qy, qx};
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 9);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      pending_distances.push_back(predict_distance(item));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic finish_sending();
      req_tvalid <= 1'b0;
   endtask

   // The receiver stalls in random bursts while gaps are on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (!allow_gaps) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(1, 9);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compares each accepted result with the oldest prediction.
   always @(posedge clock) begin
      dist_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_distances.size() == 0) begin
            report_mismatch("result with no query outstanding");
         end else begin
            want = pending_distances.pop_front();
            if (rsp_tdata[24:0] !== want.distance)
               report_mismatch($sformatf("distance got %0d want %0d",
                                         rsp_tdata[24:0], want.distance));
            if (rsp_tuser !== want.degenerate)
               report_mismatch($sformatf("degenerate got %b want %b",
                                         rsp_tuser, want.degenerate));
         end
      end
   end

   // Watchdog: counts cycles in which no transaction happens on either side and fails the run at WATCHDOG_LIMIT.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic logic [CB-1:0] random_coord();
      case ($urandom_range(0, 5))
         0: return {1'b0, {(CB-1){1'b1}}};
         1: return {1'b1, {(CB-1){1'b0}}};
         2: return CB'($urandom_range(0, 64) - 32);
         default: return CB'($urandom());
      endcase
   endfunction

   task automatic test_extremes();
      logic [CB-1:0] mx, mn;
      mx = {1'b0, {(CB-1){1'b1}}};
      mn = {1'b1, {(CB-1){1'b0}}};
      send_query(mx, mx, mn, mn, mn, mn);   // zero-length segment, farthest point
      send_query(mn, mn, mx, mx, mx, mx);
      send_query('0, '0, '0, '0, '0, '0);
      send_query(mx, mn, mn, mn, mx, mx);   // longest segment
      send_query(mn, mx, mn, mn, mx, mx);
      send_query(mx, mx, mx, mn, mn, mx);
      send_query('1, '1, '0, '0, '0, '0);
   endtask

   task automatic test_projection_cases();
      // Point behind the start, ratio clamps to zero.
      send_query(-24'sd4096, 24'd5, '0, '0, 24'd4096, '0);
      // Point past the end, ratio clamps to one.
      send_query(24'd9000, 24'd5, '0, '0, 24'd4096, '0);
      // Interior projection with a fractional ratio.
      send_query(24'd1234, 24'd777, '0, '0, 24'd4096, 24'd3000);
      send_query(24'd3, -24'sd7, 24'd1, 24'd1, -24'sd5, -24'sd9);
      // Dot product exactly zero and exactly the squared length.
      send_query('0, 24'd100, '0, '0, 24'd100, '0);
      send_query(24'd100, 24'd100, '0, '0, 24'd100, '0);
      // Point on the segment.
      send_query(24'd50, '0, '0, '0, 24'd100, '0);
      // Unit-length segment, negative direction.
      send_query(24'd7, 24'd7, 24'd1, '0, '0, '0);
   endtask

   task automatic test_random_queries(int count);
      logic [CB-1:0] sx, sy, qx, qy, ex, ey;
      for (int i = 0; i < count; i++) begin
         sx = random_coord();
         sy = random_coord();
         if ($urandom_range(0, 9) == 0) begin
            send_query(random_coord(), random_coord(), sx, sy, sx, sy);
         end else if ($urandom_range(0, 2) == 0) begin
            qx = sx + CB'($urandom_range(0, 200) - 100);
            qy = sy + CB'($urandom_range(0, 200) - 100);
            ex = sx + CB'($urandom_range(0, 60) - 30);
            ey = sy + CB'($urandom_range(0, 60) - 30);
            send_query(qx, qy, sx, sy, ex, ey);
         end else begin
            send_query(random_coord(), random_coord(), sx, sy, random_coord(), random_coord());
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_projection_cases();
      test_random_queries(1400);
      allow_gaps = 1'b0;
      test_random_queries(200);
      finish_sending();
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
